@@ rtl/core/ssig_pkg.sv @@
// Shared constants and the state record of the spiral strip index generator.
`timescale 1ns / 1ps
`default_nettype none
package ssig_pkg;

    localparam int MAX_GRID_SIZE = 1024;
    localparam int GRID_W        = 11;
    localparam int IDX_W         = 20;
    localparam int SIZE_W        = $clog2(MAX_GRID_SIZE + 1);
    localparam int POS_W         = SIZE_W + 1;
    localparam int PHASE_W       = 3;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = ((IDX_W + 7) / 8) * 8;

    localparam logic [PHASE_W-1:0] PH_OPEN0 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_OPEN1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RIGHT = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DOWN  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LEFT  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_UP    = 3'd5;

    typedef struct packed {
        logic [IDX_W-1:0]   rec0;
        logic [IDX_W-1:0]   rec1;
        logic [IDX_W-1:0]   rec2;
        logic [SIZE_W-1:0]  leg_length;
        logic [PHASE_W-1:0] leg_phase;
        logic [POS_W-1:0]   leg_position;
        logic               strip_active;
        logic [SIZE_W-1:0]  strip_size;
    } strip_state_t;

endpackage
`default_nettype wire

@@ rtl/core/spiral_strip_index_generator.sv @@
// Top level of the spiral triangle strip index generator.
// Each accepted item returns one vertex index of a triangle strip that spirals inward
// over a grid_size by grid_size vertex grid; m_tlast marks the final index of a strip,
// and the next item after it (or any item with restart set) begins a new strip at 0.
// The block accepts one item per clock and returns its index in the next cycle; that
// rate is set by the single next-state stage between the strip state registers and
// the result register. A new item can enter in the same cycle that the waiting result
// is taken, but not while that result is held off by m_tready.
// grid_size is clamped to 2..1024 and sampled only when a strip starts.
`timescale 1ns / 1ps
`default_nettype none
module spiral_strip_index_generator (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [ssig_pkg::GRID_W-1:0]          cfg_wdata,    // grid_size
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [ssig_pkg::S_TDATA_W-1:0]       s_tdata,      // [0] restart
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [ssig_pkg::M_TDATA_W-1:0]            m_tdata,      // [19:0] vertex_index
    output logic                                      m_tlast       // last_index
);

    logic [ssig_pkg::GRID_W-1:0]    grid_size_reg;
    ssig_pkg::strip_state_t         state_reg;
    ssig_pkg::strip_state_t         state_next;
    logic [ssig_pkg::IDX_W-1:0]     index_next;
    logic                           last_next;
    logic [ssig_pkg::IDX_W-1:0]     index_reg;
    logic                           last_reg;
    logic                           m_tvalid_reg;
    logic                           in_accept;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    ssig_step u_step (
        .cur          (state_reg),
        .grid_size    (grid_size_reg),
        .restart      (s_tdata[0]),
        .nxt          (state_next),
        .vertex_index (index_next),
        .last_index   (last_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= ssig_pkg::GRID_W'(17);
        end else if (cfg_we) begin
            grid_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            index_reg <= index_next;
            last_reg  <= last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ssig_pkg::M_TDATA_W'(index_reg);
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_tvalid_reg)
        else $error("accepted item produced no result");

    a_restart_opens_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tdata[0]) |=> (index_reg == '0 && !last_reg))
        else $error("restart did not open the strip at index zero");

    a_position_in_leg: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.leg_position <= {state_reg.leg_length, 1'b0})
        else $error("leg position ran past the leg length");

    a_last_ends_strip: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && last_reg) |-> !state_reg.strip_active)
        else $error("strip still active after its final index");
`endif

endmodule
`default_nettype wire

@@ rtl/core/ssig_step.sv @@
// Next-state and index logic for one item of the spiral strip.
`timescale 1ns / 1ps
`default_nettype none
module ssig_step (
    input  wire ssig_pkg::strip_state_t         cur,
    input  wire logic [ssig_pkg::GRID_W-1:0]    grid_size,
    input  wire logic                           restart,
    output ssig_pkg::strip_state_t              nxt,
    output logic [ssig_pkg::IDX_W-1:0]          vertex_index,
    output logic                                last_index
);

    logic                              start;
    logic [ssig_pkg::SIZE_W-1:0]       sat_size;
    logic [ssig_pkg::IDX_W-1:0]        addend;
    logic                              subtract;
    logic [ssig_pkg::IDX_W-1:0]        leg_sum;
    logic [ssig_pkg::POS_W-1:0]        leg_span;

    assign start = restart || !cur.strip_active || (cur.leg_phase > ssig_pkg::PH_UP);

    // The size latched at strip start is clamped to the supported range.
    always_comb begin
        if (int'(grid_size) < 2) begin
            sat_size = ssig_pkg::SIZE_W'(2);
        end else if (int'(grid_size) > ssig_pkg::MAX_GRID_SIZE) begin
            sat_size = ssig_pkg::SIZE_W'(ssig_pkg::MAX_GRID_SIZE);
        end else begin
            sat_size = ssig_pkg::SIZE_W'(grid_size);
        end
    end

    // One add/subtract serves all four legs: +1, +S, -1, -S.
    always_comb begin
        if (cur.leg_phase == ssig_pkg::PH_RIGHT || cur.leg_phase == ssig_pkg::PH_LEFT) begin
            addend = ssig_pkg::IDX_W'(1);
        end else begin
            addend = ssig_pkg::IDX_W'(cur.strip_size);
        end
        subtract = (cur.leg_phase == ssig_pkg::PH_LEFT) || (cur.leg_phase == ssig_pkg::PH_UP);
        leg_sum  = subtract ? (cur.rec1 - addend) : (cur.rec1 + addend);
    end

    assign leg_span = {cur.leg_length, 1'b0};

    always_comb begin
        nxt          = cur;
        vertex_index = '0;
        last_index   = 1'b0;
        if (start) begin
            nxt.strip_size   = sat_size;
            nxt.leg_length   = sat_size - ssig_pkg::SIZE_W'(1);
            nxt.leg_phase    = ssig_pkg::PH_OPEN1;
            nxt.leg_position = '0;
            nxt.strip_active = 1'b1;
        end else begin
            unique case (cur.leg_phase)
                ssig_pkg::PH_OPEN0: begin
                    nxt.leg_phase = ssig_pkg::PH_OPEN1;
                end
                ssig_pkg::PH_OPEN1: begin
                    vertex_index     = ssig_pkg::IDX_W'(cur.strip_size);
                    nxt.leg_phase    = ssig_pkg::PH_RIGHT;
                    nxt.leg_position = '0;
                end
                ssig_pkg::PH_RIGHT, ssig_pkg::PH_DOWN,
                ssig_pkg::PH_LEFT, ssig_pkg::PH_UP: begin
                    if (cur.leg_position < leg_span) begin
                        vertex_index     = leg_sum;
                        nxt.leg_position = cur.leg_position + ssig_pkg::POS_W'(1);
                    end else begin
                        // Turn index: repeat the index three places back.
                        vertex_index     = cur.rec2;
                        nxt.leg_position = '0;
                        unique case (cur.leg_phase)
                            ssig_pkg::PH_RIGHT: begin
                                if (cur.leg_length != '0) begin
                                    nxt.leg_length = cur.leg_length - ssig_pkg::SIZE_W'(1);
                                end
                                nxt.leg_phase = ssig_pkg::PH_DOWN;
                            end
                            ssig_pkg::PH_DOWN: begin
                                nxt.leg_phase = ssig_pkg::PH_LEFT;
                            end
                            ssig_pkg::PH_LEFT: begin
                                if (cur.leg_length != '0) begin
                                    nxt.leg_length = cur.leg_length - ssig_pkg::SIZE_W'(1);
                                end
                                nxt.leg_phase = ssig_pkg::PH_UP;
                            end
                            default: begin
                                if (cur.leg_length == '0) begin
                                    last_index       = 1'b1;
                                    nxt.strip_active = 1'b0;
                                    nxt.leg_phase    = ssig_pkg::PH_OPEN0;
                                end else begin
                                    nxt.leg_phase = ssig_pkg::PH_RIGHT;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    nxt.leg_phase = ssig_pkg::PH_OPEN1;
                end
            endcase
        end

        if (start) begin
            nxt.rec0 = '0;
            nxt.rec1 = '0;
            nxt.rec2 = '0;
        end else begin
            nxt.rec0 = vertex_index;
            nxt.rec1 = cur.rec0;
            nxt.rec2 = cur.rec1;
        end
    end

endmodule
`default_nettype wire
